/* design/sie_pkg.sv */
package sie_pkg;

  // command codes
  localparam logic [1:0] CMD_WR   = 2'd0;
  localparam logic [1:0] CMD_RD   = 2'd1;
  localparam logic [1:0] CMD_EXEC = 2'd2;

  // string operation codes
  localparam logic [2:0] OP_LODS = 3'd0;
  localparam logic [2:0] OP_STOS = 3'd1;
  localparam logic [2:0] OP_MOVS = 3'd2;
  localparam logic [2:0] OP_CMPS = 3'd3;
  localparam logic [2:0] OP_SCAS = 3'd4;

  // operand size codes
  localparam logic [1:0] SZ_BYTE  = 2'd0;
  localparam logic [1:0] SZ_WORD  = 2'd1;
  localparam logic [1:0] SZ_DWORD = 2'd2;

  // prefix codes
  localparam logic [1:0] RK_NONE = 2'd0;
  localparam logic [1:0] RK_REP  = 2'd1;
  localparam logic [1:0] RK_REPE = 2'd2;

  // memory address source
  typedef enum logic [1:0] {
    A_MEM,
    A_SRC,
    A_DST,
    A_STOS
  } addr_sel_t;

  // memory write data source
  typedef enum logic [1:0] {
    W_MEM,
    W_STOS,
    W_ABUF
  } wdata_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       take;
    logic       mem_we;
    logic       mem_re;
    addr_sel_t  asel;
    wdata_sel_t wsel;
    logic       cap_a;
    logic       cap_b;
    logic       cap_m;
    logic       bi_clr;
    logic       bi_inc;
    logic       k_set_last;
    logic       k_inc;
    logic       sb_init;
    logic       sb_inc;
    logic       eval;
    logic       fin;
    logic       out_load;
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] op;
    logic       n_zero;
    logic       bi_last;
    logic       k_last;
    logic       stos_last;
    logic       cmp_stop;
    logic       cmp_more;
    logic       cmp_tail;
  } sts_t;

  // flags of a - b at the operand size: CF,PF,AF,ZF,SF,OF in bits 0..5
  function automatic logic [5:0] sub_flags(logic [31:0] a, logic [31:0] b, logic [1:0] sz);
    logic [31:0] mask;
    logic [31:0] am;
    logic [31:0] bm;
    logic [31:0] r;
    logic [31:0] ov;
    logic        msb_r;
    logic        msb_o;
    logic [5:0]  f;
    case (sz)
      SZ_BYTE: mask = 32'h0000_00FF;
      SZ_WORD: mask = 32'h0000_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
    am = a & mask;
    bm = b & mask;
    r  = (am - bm) & mask;
    ov = (am ^ bm) & (am ^ r);
    case (sz)
      SZ_BYTE: begin
        msb_r = r[7];
        msb_o = ov[7];
      end
      SZ_WORD: begin
        msb_r = r[15];
        msb_o = ov[15];
      end
      default: begin
        msb_r = r[31];
        msb_o = ov[31];
      end
    endcase
    f[0] = (am < bm);
    f[1] = ~^r[7:0];
    f[2] = am[4] ^ bm[4] ^ r[4];
    f[3] = (r == 32'd0);
    f[4] = msb_r;
    f[5] = msb_o;
    return f;
  endfunction

endpackage

/* design/sie_in_if.sv */
interface sie_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [2:0]  op;
  logic [1:0]  size;
  logic [1:0]  rep_kind;
  logic [31:0] eax_in;
  logic [31:0] ecx_in;
  logic [31:0] esi_in;
  logic [31:0] edi_in;
  logic [5:0]  flags_in;
  logic [15:0] mem_addr;
  logic [7:0]  mem_wdata;

  modport source (
    output valid, cmd, op, size, rep_kind, eax_in, ecx_in, esi_in, edi_in,
           flags_in, mem_addr, mem_wdata,
    input  ready
  );
  modport sink (
    input  valid, cmd, op, size, rep_kind, eax_in, ecx_in, esi_in, edi_in,
           flags_in, mem_addr, mem_wdata,
    output ready
  );
endinterface

/* design/sie_out_if.sv */
interface sie_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  mem_rdata;
  logic [31:0] eax_out;
  logic [31:0] ecx_out;
  logic [31:0] esi_out;
  logic [31:0] edi_out;
  logic [5:0]  flags_out;

  modport source (
    output valid, mem_rdata, eax_out, ecx_out, esi_out, edi_out, flags_out,
    input  ready
  );
  modport sink (
    input  valid, mem_rdata, eax_out, ecx_out, esi_out, edi_out, flags_out,
    output ready
  );
endinterface

/* design/sie_dp.sv */
module sie_dp import sie_pkg::*; #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk,
  input  ctl_t        ctl,
  output sts_t        sts,
  input  logic [1:0]  cmd,
  input  logic [2:0]  op,
  input  logic [1:0]  size,
  input  logic [1:0]  rep_kind,
  input  logic [31:0] eax_in,
  input  logic [31:0] ecx_in,
  input  logic [31:0] esi_in,
  input  logic [31:0] edi_in,
  input  logic [5:0]  flags_in,
  input  logic [15:0] mem_addr,
  input  logic [7:0]  mem_wdata,
  output logic [7:0]  mem_rdata,
  output logic [31:0] eax_out,
  output logic [31:0] ecx_out,
  output logic [31:0] esi_out,
  output logic [31:0] edi_out,
  output logic [5:0]  flags_out
);

  localparam int AW = $clog2(MEM_BYTES);

  // byte memory, single port, registered read
  logic [7:0]    mem [MEM_BYTES];
  logic [7:0]    mem_q_r;
  logic [AW-1:0] mem_idx;
  logic [7:0]    mem_wd;

  // item registers
  logic [1:0]  cmd_r;
  logic [2:0]  op_r;
  logic [1:0]  sz_r;
  logic        rep_r;
  logic        rk1_r;
  logic [31:0] eax_r, ecx_r, esi_r, edi_r;
  logic [5:0]  flags_r;
  logic [15:0] maddr_r;
  logic [7:0]  wdata_r;
  logic [7:0]  rdata_r;

  // sequencing registers
  logic [31:0] n_r;
  logic [31:0] k_r;
  logic [31:0] done_r;
  logic        tail_r;
  logic [1:0]  bi_r;
  logic [33:0] sb_r;
  logic [31:0] abuf_r, bbuf_r;

  logic [33:0] total;
  logic [33:0] len;
  logic [31:0] per;
  logic [31:0] lim;
  logic [31:0] k1;
  logic [1:0]  zlast;
  logic [1:0]  lane;
  logic [7:0]  stos_byte;
  logic [31:0] a_op;
  logic [5:0]  flags_now;
  logic [31:0] kz;
  logic [31:0] nz;
  logic [31:0] dz;
  logic [31:0] addr32;
  logic        rep_in;

  // element geometry
  always_comb begin
    total = {2'b00, n_r} << sz_r;
    len   = (total < 34'(MEM_BYTES)) ? total : 34'(MEM_BYTES);
    per   = 32'(MEM_BYTES) >> sz_r;
    lim   = (n_r < per) ? n_r : per;
    k1    = k_r + 32'd1;
    kz    = k_r << sz_r;
    nz    = n_r << sz_r;
    dz    = done_r << sz_r;
    case (sz_r)
      SZ_BYTE: begin
        zlast = 2'd0;
        lane  = 2'd0;
      end
      SZ_WORD: begin
        zlast = 2'd1;
        lane  = {1'b0, sb_r[0]};
      end
      default: begin
        zlast = 2'd3;
        lane  = sb_r[1:0];
      end
    endcase
    stos_byte = eax_r[8*lane +: 8];
    a_op      = (op_r == OP_CMPS) ? abuf_r : eax_r;
    flags_now = sub_flags(a_op, bbuf_r, sz_r);
    rep_in    = (rep_kind == RK_REP) || (rep_kind == RK_REPE);
  end

  // address and write data selection
  always_comb begin
    case (ctl.asel)
      A_MEM:   addr32 = {16'd0, maddr_r};
      A_SRC:   addr32 = esi_r + kz + {30'd0, bi_r};
      A_DST:   addr32 = edi_r + kz + {30'd0, bi_r};
      A_STOS:  addr32 = edi_r + sb_r[31:0];
      default: addr32 = 32'd0;
    endcase
    mem_idx = addr32[AW-1:0];
    case (ctl.wsel)
      W_MEM:   mem_wd = wdata_r;
      W_STOS:  mem_wd = stos_byte;
      W_ABUF:  mem_wd = abuf_r[8*bi_r +: 8];
      default: mem_wd = 8'd0;
    endcase
  end

  // status to controller
  always_comb begin
    sts.cmd       = cmd_r;
    sts.op        = op_r;
    sts.n_zero    = (n_r == 32'd0);
    sts.bi_last   = (bi_r == zlast);
    sts.k_last    = (k1 == n_r);
    sts.stos_last = ((sb_r + 34'd1) == total);
    sts.cmp_stop  = rep_r && (flags_now[3] == rk1_r);
    sts.cmp_more  = (k1 < lim);
    sts.cmp_tail  = (n_r > lim) && !tail_r;
  end

  // memory array
  always_ff @(posedge clk) begin
    if (ctl.mem_we) begin
      mem[mem_idx] <= mem_wd;
    end
    if (ctl.mem_re) begin
      mem_q_r <= mem[mem_idx];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cmd_r   <= cmd;
      op_r    <= op;
      case (size)
        SZ_BYTE: sz_r <= SZ_BYTE;
        SZ_WORD: sz_r <= SZ_WORD;
        default: sz_r <= SZ_DWORD;
      endcase
      rep_r   <= rep_in;
      rk1_r   <= (rep_kind == RK_REP);
      eax_r   <= eax_in;
      ecx_r   <= ecx_in;
      esi_r   <= esi_in;
      edi_r   <= edi_in;
      flags_r <= flags_in;
      maddr_r <= mem_addr;
      wdata_r <= mem_wdata;
      n_r     <= rep_in ? ecx_in : 32'd1;
      k_r     <= 32'd0;
      bi_r    <= 2'd0;
      tail_r  <= 1'b0;
      done_r  <= 32'd0;
    end else begin
      // element and byte counters
      if (ctl.k_set_last) begin
        k_r    <= n_r - 32'd1;
        tail_r <= 1'b1;
      end else if (ctl.k_inc) begin
        k_r <= k1;
      end
      if (ctl.bi_clr) begin
        bi_r <= 2'd0;
      end else if (ctl.bi_inc) begin
        bi_r <= bi_r + 2'd1;
      end
      if (ctl.sb_init) begin
        sb_r <= total - len;
      end else if (ctl.sb_inc) begin
        sb_r <= sb_r + 34'd1;
      end
      // operand capture from memory
      if (ctl.cap_a) begin
        abuf_r[8*bi_r +: 8] <= mem_q_r;
      end
      if (ctl.cap_b) begin
        bbuf_r[8*bi_r +: 8] <= mem_q_r;
      end
      if (ctl.cap_m) begin
        rdata_r <= mem_q_r;
      end
      // compare step
      if (ctl.eval) begin
        flags_r <= flags_now;
        done_r  <= k1;
      end
      // register update at the end of an instruction
      if (ctl.fin) begin
        case (op_r)
          OP_LODS: begin
            if (n_r != 32'd0) begin
              case (sz_r)
                SZ_BYTE: eax_r <= {eax_r[31:8], abuf_r[7:0]};
                SZ_WORD: eax_r <= {eax_r[31:16], abuf_r[15:0]};
                default: eax_r <= abuf_r;
              endcase
            end
            esi_r <= esi_r + nz;
            if (rep_r) ecx_r <= 32'd0;
          end
          OP_STOS: begin
            edi_r <= edi_r + nz;
            if (rep_r) ecx_r <= 32'd0;
          end
          OP_MOVS: begin
            esi_r <= esi_r + nz;
            edi_r <= edi_r + nz;
            if (rep_r) ecx_r <= 32'd0;
          end
          OP_CMPS: begin
            esi_r <= esi_r + dz;
            edi_r <= edi_r + dz;
            if (rep_r) ecx_r <= ecx_r - done_r;
          end
          OP_SCAS: begin
            edi_r <= edi_r + dz;
            if (rep_r) ecx_r <= ecx_r - done_r;
          end
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      mem_rdata <= (cmd_r == CMD_RD) ? rdata_r : 8'd0;
      if (cmd_r == CMD_EXEC) begin
        eax_out   <= eax_r;
        ecx_out   <= ecx_r;
        esi_out   <= esi_r;
        edi_out   <= edi_r;
        flags_out <= flags_r;
      end else begin
        eax_out   <= 32'd0;
        ecx_out   <= 32'd0;
        esi_out   <= 32'd0;
        edi_out   <= 32'd0;
        flags_out <= 6'd0;
      end
    end
  end

endmodule

/* design/sie_ctrl.sv */
module sie_ctrl import sie_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_MWR,
    S_MRD,
    S_MCAP,
    S_LD_RD,
    S_LD_CAP,
    S_ST_WR,
    S_MV_RD,
    S_MV_CAP,
    S_MV_WR,
    S_CP_RDA,
    S_CP_CAPA,
    S_CP_RDB,
    S_CP_CAPB,
    S_CP_EVAL,
    S_FIN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   is_cmps;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign is_cmps   = (sts.op == OP_CMPS);

  // next state and datapath commands
  always_comb begin
    ctl           = '0;
    ctl.asel      = A_MEM;
    ctl.wsel      = W_MEM;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.take  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.sb_init = 1'b1;
        case (sts.cmd)
          CMD_WR: state_nxt = S_MWR;
          CMD_RD: state_nxt = S_MRD;
          CMD_EXEC: begin
            case (sts.op)
              OP_LODS: begin
                if (sts.n_zero) begin
                  state_nxt = S_FIN;
                end else begin
                  ctl.k_set_last = 1'b1;
                  state_nxt      = S_LD_RD;
                end
              end
              OP_STOS: state_nxt = sts.n_zero ? S_FIN : S_ST_WR;
              OP_MOVS: state_nxt = sts.n_zero ? S_FIN : S_MV_RD;
              OP_CMPS: state_nxt = sts.n_zero ? S_FIN : S_CP_RDA;
              OP_SCAS: state_nxt = sts.n_zero ? S_FIN : S_CP_RDB;
              default: state_nxt = S_FIN;
            endcase
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_MWR: begin
        ctl.mem_we = 1'b1;
        state_nxt  = S_DONE;
      end
      S_MRD: begin
        ctl.mem_re = 1'b1;
        state_nxt  = S_MCAP;
      end
      S_MCAP: begin
        ctl.cap_m = 1'b1;
        state_nxt = S_DONE;
      end
      // lods reads only the last element
      S_LD_RD: begin
        ctl.mem_re = 1'b1;
        ctl.asel   = A_SRC;
        state_nxt  = S_LD_CAP;
      end
      S_LD_CAP: begin
        ctl.cap_a = 1'b1;
        if (sts.bi_last) begin
          state_nxt = S_FIN;
        end else begin
          ctl.bi_inc = 1'b1;
          state_nxt  = S_LD_RD;
        end
      end
      // stos writes one byte a cycle
      S_ST_WR: begin
        ctl.mem_we = 1'b1;
        ctl.asel   = A_STOS;
        ctl.wsel   = W_STOS;
        ctl.sb_inc = 1'b1;
        if (sts.stos_last) state_nxt = S_FIN;
      end
      // movs: read an element, then write it
      S_MV_RD: begin
        ctl.mem_re = 1'b1;
        ctl.asel   = A_SRC;
        state_nxt  = S_MV_CAP;
      end
      S_MV_CAP: begin
        ctl.cap_a = 1'b1;
        if (sts.bi_last) begin
          ctl.bi_clr = 1'b1;
          state_nxt  = S_MV_WR;
        end else begin
          ctl.bi_inc = 1'b1;
          state_nxt  = S_MV_RD;
        end
      end
      S_MV_WR: begin
        ctl.mem_we = 1'b1;
        ctl.asel   = A_DST;
        ctl.wsel   = W_ABUF;
        if (sts.bi_last) begin
          ctl.bi_clr = 1'b1;
          if (sts.k_last) begin
            state_nxt = S_FIN;
          end else begin
            ctl.k_inc = 1'b1;
            state_nxt = S_MV_RD;
          end
        end else begin
          ctl.bi_inc = 1'b1;
        end
      end
      // cmps/scas: gather operands, then compare
      S_CP_RDA: begin
        ctl.mem_re = 1'b1;
        ctl.asel   = A_SRC;
        state_nxt  = S_CP_CAPA;
      end
      S_CP_CAPA: begin
        ctl.cap_a = 1'b1;
        if (sts.bi_last) begin
          ctl.bi_clr = 1'b1;
          state_nxt  = S_CP_RDB;
        end else begin
          ctl.bi_inc = 1'b1;
          state_nxt  = S_CP_RDA;
        end
      end
      S_CP_RDB: begin
        ctl.mem_re = 1'b1;
        ctl.asel   = A_DST;
        state_nxt  = S_CP_CAPB;
      end
      S_CP_CAPB: begin
        ctl.cap_b = 1'b1;
        if (sts.bi_last) begin
          ctl.bi_clr = 1'b1;
          state_nxt  = S_CP_EVAL;
        end else begin
          ctl.bi_inc = 1'b1;
          state_nxt  = S_CP_RDB;
        end
      end
      S_CP_EVAL: begin
        ctl.eval = 1'b1;
        if (sts.cmp_stop) begin
          state_nxt = S_FIN;
        end else if (sts.cmp_more) begin
          ctl.k_inc = 1'b1;
          state_nxt = is_cmps ? S_CP_RDA : S_CP_RDB;
        end else if (sts.cmp_tail) begin
          // addresses repeat after one memory period, only the last element remains
          ctl.k_set_last = 1'b1;
          state_nxt      = is_cmps ? S_CP_RDA : S_CP_RDB;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        ctl.fin   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          ctl.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // memory port takes one access a cycle
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.mem_we && ctl.mem_re))
    else $error("memory read and write in the same cycle");

  // an accepted item makes the block busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after an item was taken");

  // a result is loaded only into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  // every capture follows a memory read
  a_cap_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cap_a || ctl.cap_b || ctl.cap_m) |-> $past(ctl.mem_re))
    else $error("capture without a preceding read");

endmodule

/* design/x86_string_instruction_engine.sv */
// x86 string instruction engine: lods, stos, movs, cmps and scas over a local
// byte memory, plus single byte memory write and read commands.
// in_ch carries one item per valid/ready handshake: a command, the operation,
// size, prefix kind, eax/ecx/esi/edi, flags and the memory address and data.
// out_ch returns exactly one item per input item: the read byte and the
// updated registers and flags (all zero for memory commands).
// The block works on one item at a time; in_ch.ready is high only when idle.
// Every memory access goes through the single memory port, one byte per access
// with a registered read, so the time an item takes follows its byte count:
// lods reads only the bytes of the last element, stos writes at most MEM_BYTES
// bytes, movs reads and writes every byte moved, cmps reads both operands and
// scas one operand of each element compared, and an execute with a zero count
// or an unknown op goes straight to the final register update. in_ch.ready
// comes back in the same cycle that out_ch.valid rises.
// The result sits in an output register; the engine returns to idle and
// takes the next item while a stalled result waits, and finishes that item
// only up to its final load until the receiver takes the earlier result.
// Reset clears the controller only; memory contents are undefined until written.
module x86_string_instruction_engine import sie_pkg::*; #(
  parameter int MEM_BYTES = 65536
) (
  input logic    clk,
  input logic    rst_n,
  sie_in_if.sink in_ch,
  sie_out_if.source out_ch
);

  ctl_t ctl;
  sts_t sts;

  sie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  sie_dp #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dp (
    .clk       (clk),
    .ctl       (ctl),
    .sts       (sts),
    .cmd       (in_ch.cmd),
    .op        (in_ch.op),
    .size      (in_ch.size),
    .rep_kind  (in_ch.rep_kind),
    .eax_in    (in_ch.eax_in),
    .ecx_in    (in_ch.ecx_in),
    .esi_in    (in_ch.esi_in),
    .edi_in    (in_ch.edi_in),
    .flags_in  (in_ch.flags_in),
    .mem_addr  (in_ch.mem_addr),
    .mem_wdata (in_ch.mem_wdata),
    .mem_rdata (out_ch.mem_rdata),
    .eax_out   (out_ch.eax_out),
    .ecx_out   (out_ch.ecx_out),
    .esi_out   (out_ch.esi_out),
    .edi_out   (out_ch.edi_out),
    .flags_out (out_ch.flags_out)
  );

endmodule

/* bench/x86_string_instruction_engine_test.sv */
`timescale 1ns / 100ps

module x86_string_instruction_engine_test import sie_pkg::*; ();

  // codes outside the named set, all of them defined as no-ops or aliases
  localparam logic [1:0] CMD_NOP      = 2'd3;
  localparam logic [2:0] OP_NOP_LO    = 3'd5;
  localparam logic [2:0] OP_NOP_HI    = 3'd7;
  localparam logic [1:0] SZ_DWORD_ALT = 2'd3;
  localparam logic [1:0] RK_NONE_ALT  = 2'd3;

  localparam int RANDOM_ITEMS = 1825;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [1:0]  cmd;
    logic [2:0]  op;
    logic [1:0]  size;
    logic [1:0]  rep_kind;
    logic [31:0] eax;
    logic [31:0] ecx;
    logic [31:0] esi;
    logic [31:0] edi;
    logic [5:0]  flags;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic [31:0] eax;
    logic [31:0] ecx;
    logic [31:0] esi;
    logic [31:0] edi;
    logic [5:0]  flags;
  } reg_state_t;

  typedef struct {
    cmd_item_t  item;
    bit         known;
    reg_state_t res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  sie_in_if  in_ch();
  sie_out_if out_ch();

  x86_string_instruction_engine i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // shadow of the byte memory
  logic [7:0]  shadow_mem [0:65535];
  bit          shadow_set [0:65535];
  reg_state_t  pending_results[$];
  int          mismatches;
  int          cycles;
  int          big_fills_left;
  bit          quiet;
  stim_row_t   stim_rows[$];

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] fetch_elem(logic [31:0] a, int z);
    logic [31:0] v;
    logic [15:0] p;
    v = '0;
    for (int i = 0; i < z; i++) begin
      p = a[15:0] + 16'(i);
      if (!shadow_set[p]) $display("note: unwritten byte at %h read", p);
      v |= 32'(shadow_mem[p]) << (8 * i);
    end
    return v;
  endfunction

  // flags of a - b at z bytes: CF,PF,AF,ZF,SF,OF
  function automatic logic [5:0] compare_flags(logic [31:0] a, logic [31:0] b, int z);
    logic [31:0] m;
    logic [31:0] d;
    logic [31:0] ov;
    int          top;
    logic [5:0]  f;
    m   = (z == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * z)) - 1);
    top = 8 * z - 1;
    a   = a & m;
    b   = b & m;
    d   = (a - b) & m;
    ov  = (a ^ b) & (a ^ d);
    f[0] = a < b;
    f[1] = ~^d[7:0];
    f[2] = a[4] ^ b[4] ^ d[4];
    f[3] = d == 0;
    f[4] = d[top];
    f[5] = ov[top];
    return f;
  endfunction

  function automatic void store_byte(logic [15:0] p, logic [7:0] v);
    shadow_mem[p] = v;
    shadow_set[p] = 1'b1;
  endfunction

  // predicted registers and flags after one item, memory updated in place
  function automatic reg_state_t run_string_op(cmd_item_t it);
    reg_state_t     o;
    int             z;
    bit             rep;
    bit             stop;
    logic [31:0]    n;
    logic [31:0]    v;
    logic [31:0]    a;
    logic [31:0]    b;
    logic [31:0]    done;
    logic [7:0]     tmp [4];
    longint unsigned total;
    longint unsigned len;
    o = '{default: '0};
    case (it.cmd)
      CMD_WR: begin
        store_byte(it.addr, it.wdata);
        return o;
      end
      CMD_RD: begin
        o.rdata = 8'(fetch_elem({16'd0, it.addr}, 1));
        return o;
      end
      CMD_EXEC: ;
      default: return o;
    endcase
    z   = (it.size == SZ_BYTE) ? 1 : ((it.size == SZ_WORD) ? 2 : 4);
    rep = (it.rep_kind == RK_REP) || (it.rep_kind == RK_REPE);
    n   = rep ? it.ecx : 32'd1;
    o.eax = it.eax;
    o.ecx = it.ecx;
    o.esi = it.esi;
    o.edi = it.edi;
    o.flags = it.flags;
    case (it.op)
      OP_LODS: begin
        if (n != 0) begin
          v = fetch_elem(it.esi + (n - 1) * z, z);
          if (z == 1) o.eax = {it.eax[31:8], v[7:0]};
          else if (z == 2) o.eax = {it.eax[31:16], v[15:0]};
          else o.eax = v;
        end
        o.esi = it.esi + n * z;
        if (rep) o.ecx = '0;
      end
      OP_STOS: begin
        total = longint'(n) * z;
        len = (total < 65536) ? total : 65536;
        for (longint unsigned k = total - len; k < total; k++)
          store_byte(it.edi[15:0] + 16'(k), 8'(it.eax >> (8 * (k % z))));
        o.edi = it.edi + n * z;
        if (rep) o.ecx = '0;
      end
      OP_MOVS: begin
        // counts stay far below one address period
        for (int k = 0; k < n; k++) begin
          for (int i = 0; i < z; i++) tmp[i] = 8'(fetch_elem(it.esi + k * z + i, 1));
          for (int i = 0; i < z; i++) store_byte(it.edi[15:0] + 16'(k * z + i), tmp[i]);
        end
        o.esi = it.esi + n * z;
        o.edi = it.edi + n * z;
        if (rep) o.ecx = '0;
      end
      OP_CMPS, OP_SCAS: begin
        done = 0;
        stop = 1'b0;
        for (int k = 0; k < n && !stop; k++) begin
          a = (it.op == OP_CMPS) ? fetch_elem(it.esi + k * z, z) : it.eax;
          b = fetch_elem(it.edi + k * z, z);
          o.flags = compare_flags(a, b, z);
          done = k + 1;
          if (rep && (o.flags[3] == (it.rep_kind == RK_REP))) stop = 1'b1;
        end
        if (it.op == OP_CMPS) o.esi = it.esi + done * z;
        o.edi = it.edi + done * z;
        if (rep) o.ecx = it.ecx - done;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic cmd_item_t mk(logic [1:0] cmd, logic [2:0] op, logic [1:0] size,
                                   logic [1:0] rk, logic [31:0] eax, logic [31:0] ecx,
                                   logic [31:0] esi, logic [31:0] edi, logic [5:0] flags,
                                   logic [15:0] addr, logic [7:0] wdata);
    cmd_item_t it;
    it = '{cmd, op, size, rk, eax, ecx, esi, edi, flags, addr, wdata};
    return it;
  endfunction

  function automatic void add_row(cmd_item_t it, bit known, logic [7:0] rdata);
    stim_row_t r;
    r.item  = it;
    r.known = known;
    r.res   = '{default: '0};
    r.res.rdata = rdata;
    stim_rows.push_back(r);
  endfunction

  function automatic cmd_item_t random_item();
    cmd_item_t it;
    int        r;
    bit        rep;
    it = mk(2'($urandom), 3'($urandom), 2'($urandom), 2'($urandom), $urandom, $urandom,
            $urandom, $urandom, 6'($urandom), 16'($urandom), 8'($urandom));
    r = $urandom_range(0, 99);
    if (r < 12) it.cmd = CMD_WR;
    else if (r < 20) it.cmd = CMD_RD;
    else if (r < 22) it.cmd = CMD_NOP;
    else begin
      it.cmd = CMD_EXEC;
      it.op = ($urandom_range(0, 99) < 5) ? 3'($urandom_range(OP_NOP_LO, OP_NOP_HI))
                                          : 3'($urandom_range(OP_LODS, OP_SCAS));
      rep = (it.rep_kind == RK_REP) || (it.rep_kind == RK_REPE);
      if (rep && it.op <= OP_SCAS) begin
        if (it.op == OP_STOS && big_fills_left > 0 && $urandom_range(0, 199) == 0)
          big_fills_left--;
        else if (!(it.op == OP_LODS && $urandom_range(0, 7) == 0))
          it.ecx = $urandom_range(0, 12);
      end
      if ($urandom_range(0, 7) == 0) it.esi = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      if ($urandom_range(0, 7) == 0) it.edi = 32'hFFFF_FFF0 + $urandom_range(0, 15);
    end
    return it;
  endfunction

  // one item onto the input channel; returns after the accepting edge, with valid dropped
  task automatic send_item(cmd_item_t it, bit known, reg_state_t given);
    int gap;
    reg_state_t pred;
    gap = pick_gap();
    repeat (gap) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.cmd      = it.cmd;
    in_ch.op       = it.op;
    in_ch.size     = it.size;
    in_ch.rep_kind = it.rep_kind;
    in_ch.eax_in   = it.eax;
    in_ch.ecx_in   = it.ecx;
    in_ch.esi_in   = it.esi;
    in_ch.edi_in   = it.edi;
    in_ch.flags_in = it.flags;
    in_ch.mem_addr = it.addr;
    in_ch.mem_wdata = it.wdata;
    do @(posedge clk); while (!in_ch.ready);
    pred = run_string_op(it);
    pending_results.push_back(known ? given : pred);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // receiver stalls
  always @(negedge clk) begin : ready_gen
    int hold;
    if (!rst_n) begin
      hold = 0;
      out_ch.ready = 1'b0;
    end else if (hold > 0) begin
      hold--;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
      hold = pick_gap();
    end
  end

  // result check against the oldest prediction
  always @(posedge clk) begin : result_check
    reg_state_t want;
    reg_state_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.mem_rdata, out_ch.eax_out, out_ch.ecx_out, out_ch.esi_out,
              out_ch.edi_out, out_ch.flags_out};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    big_fills_left = 3;
    quiet = 1'b0;
    rst_n = 1'b0;
    out_ch.ready = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_WR;
    in_ch.op = OP_LODS;
    in_ch.size = SZ_BYTE;
    in_ch.rep_kind = RK_NONE;
    in_ch.eax_in = '0;
    in_ch.ecx_in = '0;
    in_ch.esi_in = '0;
    in_ch.edi_in = '0;
    in_ch.flags_in = '0;
    in_ch.mem_addr = '0;
    in_ch.mem_wdata = '0;
    for (int i = 0; i < 65536; i++) begin
      shadow_mem[i] = '0;
      shadow_set[i] = 1'b0;
    end

    // directed rows: memory extremes first, then every operation
    add_row(mk(CMD_WR, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0000, 8'h80), 1, 8'h00);
    add_row(mk(CMD_WR, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 8'hFF), 1, 8'h00);
    add_row(mk(CMD_WR, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0001, 8'h01), 1, 8'h00);
    add_row(mk(CMD_WR, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0002, 8'h7F), 1, 8'h00);
    add_row(mk(CMD_WR, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0003, 8'h00), 1, 8'h00);
    add_row(mk(CMD_RD, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 8'h00), 1, 8'hFF);
    add_row(mk(CMD_RD, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0000, 8'h00), 1, 8'h80);
    add_row(mk(CMD_NOP, OP_NOP_HI, SZ_DWORD_ALT, RK_NONE_ALT, '1, '1, '1, '1, '1,
               16'hFFFF, 8'hFF), 1, 8'h00);
    add_row(mk(CMD_EXEC, OP_STOS, SZ_DWORD, RK_REP, 32'hDEAD_BEEF, 4, 0, 4, 0, 0, 0), 0, 0);
    add_row(mk(CMD_EXEC, OP_STOS, SZ_BYTE, RK_NONE, 32'h5A, 9, 0, '1, 6'h3F, 0, 0), 0, 0);
    add_row(mk(CMD_EXEC, OP_LODS, SZ_BYTE, RK_NONE, '1, 0, '1, 0, 0, 0, 0), 0, 0);
    add_row(mk(CMD_EXEC, OP_LODS, SZ_WORD, RK_REP, '1, 3, 0, 0, 0, 0, 0), 0, 0);
    add_row(mk(CMD_EXEC, OP_LODS, SZ_DWORD, RK_REPE, 32'h1234_5678, 0, 8, 0, 0, 0, 0), 0, 0);
    add_row(mk(CMD_EXEC, OP_MOVS, SZ_WORD, RK_REP, 0, 2, 4, 32'h20, 0, 0, 0), 0, 0);
    add_row(mk(CMD_EXEC, OP_CMPS, SZ_BYTE, RK_REPE, 0, 4, 4, 32'h20, 0, 0, 0), 0, 0);
    add_row(mk(CMD_EXEC, OP_CMPS, SZ_DWORD, RK_REP, 0, 3, 0, 4, 0, 0, 0), 0, 0);
    add_row(mk(CMD_EXEC, OP_SCAS, SZ_WORD, RK_REP, 32'hBEEF, 5, 0, 4, 0, 0, 0), 0, 0);
    add_row(mk(CMD_EXEC, OP_SCAS, SZ_BYTE, RK_NONE, 0, 7, 0, 32'h0000_FFFF, 0, 0, 0), 0, 0);
    add_row(mk(CMD_EXEC, OP_CMPS, SZ_WORD, RK_REPE, 1, 0, 2, 3, 6'h15, 0, 0), 0, 0);
    add_row(mk(CMD_EXEC, OP_LODS, SZ_DWORD_ALT, RK_NONE, 0, 0, 0, 0, 0, 0, 0), 0, 0);
    add_row(mk(CMD_EXEC, OP_STOS, SZ_BYTE, RK_NONE_ALT, 32'hC3, 5, 0, 32'h30, 0, 0, 0), 0, 0);
    add_row(mk(CMD_EXEC, OP_NOP_LO, SZ_WORD, RK_REP, 1, 2, 3, 4, 6'h3F, 0, 0), 0, 0);
    add_row(mk(CMD_EXEC, OP_NOP_HI, SZ_DWORD_ALT, RK_NONE_ALT, '1, '1, '1, '1, 0, 0, 0), 0, 0);
    // whole memory filled: every later read hits a written byte
    add_row(mk(CMD_EXEC, OP_STOS, SZ_BYTE, RK_REP, 32'hA5, '1, 0, 32'h8000, 0, 0, 0), 0, 0);
    add_row(mk(CMD_EXEC, OP_SCAS, SZ_DWORD, RK_REPE, 32'hA5A5_A5A5, 6, 0, 0, 0, 0, 0), 0, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[i]) send_item(stim_rows[i].item, stim_rows[i].known, stim_rows[i].res);

    // random items, with stretches of no idling and one full drain
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = ((i / 250) % 3) == 1;
      if (i == RANDOM_ITEMS / 2)
        while (pending_results.size() != 0) @(negedge clk);
      send_item(random_item(), 1'b0, '{default: '0});
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
design/sie_pkg.sv
design/sie_in_if.sv
design/sie_out_if.sv
design/sie_dp.sv
design/sie_ctrl.sv
design/x86_string_instruction_engine.sv
bench/x86_string_instruction_engine_test.sv
